[rtl/assert_macros.svh]
// Assertion helpers shared by the pool allocator RTL.
// Included by the controller and datapath modules; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define OBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define OBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/oba_pkg.sv]
// Shared types, sizes and codes for the owned block pool allocator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package oba_pkg;

  // Pool geometry
  localparam int MaxBlocks  = 8;
  localparam int BlockBytes = 32;
  localparam int SlotW      = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int CountW     = $clog2(MaxBlocks + 1);
  localparam int AddrW      = 16;
  localparam int TaskW      = 8;
  // Wide enough for base plus the largest slot offset, no wrap
  localparam int CandW      = $clog2(65536 + MaxBlocks * BlockBytes);

  // Register port
  localparam int PaddrW     = 3;
  localparam int PdataW     = 32;
  localparam int RegSelBit  = 2;
  localparam logic RegBase  = 1'b0;
  localparam logic RegLimit = 1'b1;
  localparam logic [AddrW-1:0] BaseReset  = 16'd256;
  localparam logic [AddrW-1:0] LimitReset = 16'd2048;

  // Request codes (unused code acts as a query)
  localparam logic [1:0] ReqAlloc = 2'd0;
  localparam logic [1:0] ReqFree  = 2'd1;
  localparam logic [1:0] ReqQuery = 2'd2;

  // Status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StHeap     = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StOwner    = 3'd4;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TaskW-1:0] task_id;
    logic [AddrW-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] granted_address;
    logic [6:0]       free_count;
  } rsp_t;

  typedef struct packed {
    logic [AddrW-1:0] base_address;
    logic [AddrW-1:0] heap_limit;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;  // capture the input item
    logic exec;      // evaluate, update pool state, load result register
  } ctrl_cmd_t;

endpackage

[rtl/oba_regs.sv]
// Configuration registers of the pool allocator behind an APB-style port.
// Depends on oba_pkg.
`timescale 1ns / 1ps

module oba_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [oba_pkg::PaddrW-1:0] paddr,
  input  logic [oba_pkg::PdataW-1:0] pwdata,
  output logic [oba_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output oba_pkg::cfg_t              cfg_o
);

  logic [oba_pkg::AddrW-1:0] base_q, base_d;
  logic [oba_pkg::AddrW-1:0] limit_q, limit_d;
  logic                      wr_en;
  logic                      sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = paddr[oba_pkg::RegSelBit];

  // Decode the write
  always_comb begin
    base_d  = base_q;
    limit_d = limit_q;
    if (wr_en) begin
      unique case (sel)
        oba_pkg::RegBase:  base_d  = pwdata[oba_pkg::AddrW-1:0];
        oba_pkg::RegLimit: limit_d = pwdata[oba_pkg::AddrW-1:0];
        default:           base_d  = base_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (sel)
      oba_pkg::RegBase:  prdata = oba_pkg::PdataW'(base_q);
      oba_pkg::RegLimit: prdata = oba_pkg::PdataW'(limit_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= oba_pkg::BaseReset;
      limit_q <= oba_pkg::LimitReset;
    end else begin
      base_q  <= base_d;
      limit_q <= limit_d;
    end
  end

  assign cfg_o.base_address = base_q;
  assign cfg_o.heap_limit   = limit_q;

endmodule

[rtl/oba_ctrl.sv]
// Controller of the pool allocator: input/output handshake and sequencing.
// Depends on oba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output oba_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   exec;

  // Take an item only when idle; commit once the result slot is free
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign exec   = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.load_req = accept;
  assign cmd_o.exec     = exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Raise on a new result, drop once the old one is taken
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `OBA_ASSERT(a_accept_then_exec, clk_i, rst_ni, accept |=> (state_q == S_EXEC), "accepted item not executed")
  `OBA_ASSERT(a_exec_gives_result, clk_i, rst_ni, exec |=> out_valid_q, "executed item produced no result")
  `OBA_ASSERT(a_exec_waits, clk_i, rst_ni, ((state_q == S_EXEC) && out_valid_q && out_stall_i) |=> (state_q == S_EXEC), "result overwritten while stalled")

endmodule

[rtl/oba_dp.sv]
// Datapath of the pool allocator: request register, used map, owner tags,
// used count, slot search, address checks and the result register.
// Depends on oba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oba_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  oba_pkg::ctrl_cmd_t cmd_i,
  input  oba_pkg::cfg_t      cfg_i,
  input  oba_pkg::req_t      req_i,
  output oba_pkg::rsp_t      rsp_o
);

  oba_pkg::req_t                req_q;
  oba_pkg::rsp_t                rsp_q, rsp_d;
  logic [oba_pkg::MaxBlocks-1:0] used_q, used_d;
  logic [oba_pkg::CountW-1:0]    count_q, count_d;
  logic [oba_pkg::TaskW-1:0]     owner_q [oba_pkg::MaxBlocks];

  logic                          alloc_found;
  logic [oba_pkg::SlotW-1:0]     alloc_slot;
  logic [oba_pkg::CandW-1:0]     cand;
  logic [oba_pkg::AddrW-1:0]     off;
  logic [oba_pkg::MaxBlocks-1:0] hit;
  logic [oba_pkg::SlotW-1:0]     free_slot;
  logic                          tag_we;
  logic [oba_pkg::SlotW-1:0]     tag_slot;

  // Lowest free slot
  always_comb begin
    alloc_found = 1'b0;
    alloc_slot  = '0;
    for (int i = 0; i < oba_pkg::MaxBlocks; i++) begin
      if (!used_q[i] && !alloc_found) begin
        alloc_found = 1'b1;
        alloc_slot  = oba_pkg::SlotW'(i);
      end
    end
  end

  // Candidate block address, computed without wrap
  assign cand = oba_pkg::CandW'(cfg_i.base_address)
              + oba_pkg::CandW'(alloc_slot) * oba_pkg::CandW'(oba_pkg::BlockBytes);

  // Match the freed offset against each slot's offset
  assign off = req_q.block_address - cfg_i.base_address;
  always_comb begin
    hit       = '0;
    free_slot = '0;
    for (int i = 0; i < oba_pkg::MaxBlocks; i++) begin
      hit[i] = (oba_pkg::CandW'(off) == oba_pkg::CandW'(i * oba_pkg::BlockBytes));
      if (hit[i]) begin
        free_slot = oba_pkg::SlotW'(i);
      end
    end
  end

  // Evaluate the request
  always_comb begin
    used_d   = used_q;
    count_d  = count_q;
    tag_we   = 1'b0;
    tag_slot = alloc_slot;
    rsp_d.status          = oba_pkg::StOk;
    rsp_d.granted_address = '0;
    unique case (req_q.req_type)
      oba_pkg::ReqAlloc: begin
        priority if (count_q >= oba_pkg::CountW'(oba_pkg::MaxBlocks) || !alloc_found) begin
          rsp_d.status = oba_pkg::StFull;
        end else if (cand == '0 || cand > oba_pkg::CandW'(cfg_i.heap_limit)) begin
          rsp_d.status = oba_pkg::StHeap;
        end else begin
          used_d[alloc_slot]    = 1'b1;
          count_d               = count_q + 1'b1;
          tag_we                = 1'b1;
          rsp_d.granted_address = cand[oba_pkg::AddrW-1:0];
        end
      end
      oba_pkg::ReqFree: begin
        tag_slot = free_slot;
        priority if (req_q.block_address < cfg_i.base_address || hit == '0
                     || !used_q[free_slot]) begin
          rsp_d.status = oba_pkg::StNotFound;
        end else if (owner_q[free_slot] != req_q.task_id) begin
          rsp_d.status = oba_pkg::StOwner;
        end else begin
          used_d[free_slot] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      default: begin
        // Query and the unused code: report only
      end
    endcase
    rsp_d.free_count = 7'(oba_pkg::MaxBlocks) - 7'(count_d);
  end

  // Pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      used_q  <= used_d;
      count_q <= count_d;
    end
  end

  // Request, owner tags and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
      if (tag_we) begin
        owner_q[tag_slot] <= req_q.task_id;
      end
    end
  end

  assign rsp_o = rsp_q;

  `OBA_ASSERT(a_count_matches_map, clk_i, rst_ni, $countones(used_q) == int'(count_q), "used count out of step with used map")
  `OBA_ASSERT(a_count_bounded, clk_i, rst_ni, count_q <= oba_pkg::CountW'(oba_pkg::MaxBlocks), "used count above pool size")
  `OBA_ASSERT(a_grant_only_ok, clk_i, rst_ni, (cmd_i.exec && rsp_d.status != oba_pkg::StOk) |=> (rsp_q.granted_address == '0), "address granted on a failed request")

endmodule

[rtl/owned_block_pool_allocator.sv]
// Top level of the owned block pool allocator.
// Depends on oba_pkg, oba_regs, oba_ctrl and oba_dp.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------
//   request  | in_valid_i/in_stall_o | in_item_i  (req_t)
//   result   | out_valid_o/out_stall_i | out_item_o (rsp_t)
//   config   | psel/penable/pwrite   | paddr, pwdata, prdata
//
// Each item is first captured; its execute step then searches the used map,
// checks the address and updates pool state. No new item is taken until that
// execute step is done. The result register frees the input side: a new item
// is accepted while the previous result waits. A stalled result holds the
// execute step until it is taken. Reset clears the used map and count at
// once; no clearing pass is needed.
`timescale 1ns / 1ps

module owned_block_pool_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  oba_pkg::req_t              in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output oba_pkg::rsp_t              out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [oba_pkg::PaddrW-1:0] paddr,
  input  logic [oba_pkg::PdataW-1:0] pwdata,
  output logic [oba_pkg::PdataW-1:0] prdata,
  output logic                       pready
);

  oba_pkg::cfg_t      cfg;
  oba_pkg::ctrl_cmd_t cmd;

  oba_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  oba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  oba_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .req_i  (in_item_i),
    .rsp_o  (out_item_o)
  );

endmodule

[sim/oba_pool_checker.sv]
// Result checker for the owned block pool allocator: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on oba_pkg for the item types, codes and pool geometry.
`timescale 1ns / 1ps

module oba_pool_checker
  import oba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  req_t                in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rsp_t                out_item_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [PaddrW-1:0]   paddr_i,
  input  logic [PdataW-1:0]   pwdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int ReportMax = 10;

  // Shadow of the pool and its registers
  logic [MaxBlocks-1:0] pool_used;
  logic [TaskW-1:0]     pool_owner [MaxBlocks];
  int                   pool_cnt;
  logic [AddrW-1:0]     cur_base;
  logic [AddrW-1:0]     cur_limit;

  rsp_t rsp_due_q [$];
  int   mismatches;
  int   rsp_seen;

  // Serve one request against the shadow pool and return its result
  function automatic rsp_t serve_request(input req_t r);
    rsp_t o;
    int   s;
    int   off;
    int   cand;
    o.status          = StOk;
    o.granted_address = '0;
    case (r.req_type)
      ReqAlloc: begin
        s = 0;
        while (s < MaxBlocks && pool_used[s]) s++;
        if (pool_cnt >= MaxBlocks || s >= MaxBlocks) begin
          o.status = StFull;
        end else begin
          cand = int'(cur_base) + s * BlockBytes;
          if (cand == 0 || cand > int'(cur_limit)) begin
            o.status = StHeap;
          end else begin
            pool_used[s]      = 1'b1;
            pool_owner[s]     = r.task_id;
            pool_cnt++;
            o.granted_address = AddrW'(cand);
          end
        end
      end
      ReqFree: begin
        if (r.block_address < cur_base) begin
          o.status = StNotFound;
        end else begin
          off = int'(r.block_address) - int'(cur_base);
          s   = off / BlockBytes;
          if (off % BlockBytes != 0 || s >= MaxBlocks || !pool_used[s]) begin
            o.status = StNotFound;
          end else if (pool_owner[s] != r.task_id) begin
            o.status = StOwner;
          end else begin
            pool_used[s]  = 1'b0;
            pool_owner[s] = '0;
            if (pool_cnt > 0) pool_cnt--;
          end
        end
      end
      default: ;  // query, and the unused code that acts as one
    endcase
    o.free_count = 7'(MaxBlocks - pool_cnt);
    return o;
  endfunction

  // Compare results first, then predict the item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      pool_used = '0;
      pool_cnt  = 0;
      for (int i = 0; i < MaxBlocks; i++) pool_owner[i] = '0;
      cur_base  = BaseReset;
      cur_limit = LimitReset;
      rsp_due_q.delete();
      mismatches   = 0;
      rsp_seen     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        rsp_seen++;
        if (rsp_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("%0t: result %0d arrived with nothing expected: status %0d addr %h free %0d",
                     $time, rsp_seen, out_item_i.status, out_item_i.granted_address,
                     out_item_i.free_count);
        end else begin
          want = rsp_due_q.pop_front();
          if (out_item_i.status != want.status ||
              out_item_i.granted_address != want.granted_address ||
              out_item_i.free_count != want.free_count) begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display("%0t: result %0d expected status %0d addr %h free %0d, got status %0d addr %h free %0d",
                       $time, rsp_seen, want.status, want.granted_address, want.free_count,
                       out_item_i.status, out_item_i.granted_address, out_item_i.free_count);
          end
        end
      end
      if (in_valid_i && !in_stall_i) rsp_due_q.push_back(serve_request(in_item_i));
      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[RegSelBit] == RegBase) cur_base = pwdata_i[AddrW-1:0];
        else cur_limit = pwdata_i[AddrW-1:0];
      end
      fail_count_o <= mismatches;
      pending_o    <= rsp_due_q.size();
    end
  end

endmodule

[sim/tb.sv]
// Testbench top for the owned block pool allocator: clock, reset, requests,
// register writes and result stalls, plus the verdict.
// Depends on oba_pkg, owned_block_pool_allocator and oba_pool_checker.
`timescale 1ns / 1ps

module tb;
  import oba_pkg::*;

  localparam int NumPhases     = 9;
  localparam int PhaseItems    = 85;
  localparam int WatchdogLimit = 2000;
  // Spare request code, served as a query
  localparam logic [1:0] ReqSpare = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  req_t              in_item_i;
  logic              out_valid_o;
  logic              out_stall_i;
  rsp_t              out_item_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  int               fail_count;
  int               pending;
  int               sent;
  int               stall_left;
  int               stuck;
  logic             idle_on;
  logic [AddrW-1:0] cfg_base;
  logic [TaskW-1:0] owner_ids [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

  owned_block_pool_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  oba_pool_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 25) : $urandom_range(0, 2);
  endfunction

  // Stall the result side at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left  <= gap_len();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      stuck <= 0;
    end else if (stuck >= WatchdogLimit) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               WatchdogLimit, pending);
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // Offer one item, after an optional gap, and hold it until taken
  task automatic send_item(input logic [1:0] kind, input logic [TaskW-1:0] id,
                           input logic [AddrW-1:0] addr);
    int   gap;
    req_t item;
    gap                = idle_on ? gap_len() : 0;
    item.req_type      = kind;
    item.task_id       = id;
    item.block_address = addr;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // Drop valid and wait until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write one register through the setup and access cycles
  task automatic program_reg(input logic sel, input logic [AddrW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(sel) << RegSelBit;
    pwdata  <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Try to free every slot with each of the four listed owners
  task automatic sweep_frees();
    for (int s = 0; s < MaxBlocks; s++)
      for (int k = 0; k < 4; k++)
        send_item(ReqFree, owner_ids[k], cfg_base + AddrW'(s * BlockBytes));
  endtask

  // One random request: mostly well-formed alloc/free, some queries and noise
  task automatic random_request(input int alloc_pct);
    int               r;
    logic [AddrW-1:0] near;
    r    = $urandom_range(0, 99);
    near = cfg_base + AddrW'($urandom_range(0, MaxBlocks) * BlockBytes);
    if (r < alloc_pct) begin
      send_item(ReqAlloc, owner_ids[$urandom_range(0, 3)], AddrW'($urandom));
    end else if (r < alloc_pct + 35) begin
      send_item(ReqFree, owner_ids[$urandom_range(0, 3)], near);
    end else if (r < alloc_pct + 42) begin
      send_item(($urandom_range(0, 1) == 0) ? ReqQuery : ReqSpare, TaskW'($urandom),
                AddrW'($urandom));
    end else if (r < alloc_pct + 50) begin
      // address on or next to a slot boundary, random task
      send_item(ReqFree, TaskW'($urandom), near + AddrW'($urandom_range(0, 2)) - 16'd1);
    end else begin
      send_item(2'($urandom), TaskW'($urandom), AddrW'($urandom));
    end
  endtask

  initial begin
    logic [AddrW-1:0] phase_base  [NumPhases] = '{16'd256, 16'h0000, 16'hFFE0, 16'hFFFF,
                                                  16'h1000, 16'd100, 16'h0040, 16'h0000,
                                                  16'd256};
    logic [AddrW-1:0] phase_limit [NumPhases] = '{16'd2048, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                                  16'h1060, 16'h0000, 16'h0120, 16'h0000,
                                                  16'd2048};
    int               start;
    int               alloc_pct;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_on     = 1'b1;
    sent        = 0;
    cfg_base    = BaseReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill, overflow, every kind of failed free, reuse of slot zero
    send_item(ReqQuery, 8'h00, 16'h0000);
    send_item(ReqSpare, 8'hFF, 16'hFFFF);
    for (int i = 0; i < MaxBlocks; i++) send_item(ReqAlloc, owner_ids[i % 4], 16'hFFFF);
    send_item(ReqAlloc, 8'h77, 16'h0000);
    send_item(ReqFree, 8'hFF, 16'd256);
    send_item(ReqFree, 8'h00, 16'd256);
    send_item(ReqFree, 8'h00, 16'd256);
    send_item(ReqFree, 8'h00, 16'd255);
    send_item(ReqFree, 8'hFF, 16'd289);
    send_item(ReqFree, 8'h00, 16'd256 + 16'(MaxBlocks * BlockBytes));
    send_item(ReqFree, 8'hFF, 16'hFFFF);
    send_item(ReqAlloc, 8'h5A, 16'h0000);
    send_item(ReqFree, 8'hA5, 16'd256 + 16'(7 * BlockBytes));
    send_item(ReqQuery, 8'hFF, 16'h0000);

    // Random phases, each after programming its base and limit registers
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      repeat (4) @(posedge clk_i);
      if (p == 7) begin
        phase_base[p]  = AddrW'($urandom_range(0, 16'h8000));
        phase_limit[p] = phase_base[p] + AddrW'($urandom_range(0, 320));
      end
      program_reg(RegBase, phase_base[p]);
      program_reg(RegLimit, phase_limit[p]);
      cfg_base  = phase_base[p];
      idle_on   = (p % 3 != 1);
      alloc_pct = $urandom_range(25, 50);
      start     = sent;
      while (sent - start < PhaseItems) begin
        if (p == 3 && sent - start == 40) drain_results();
        if ($urandom_range(0, 99) < 3) sweep_frees();
        else random_request(alloc_pct);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Served %0d allocate/free/query requests across %0d register settings,",
             sent, NumPhases);
    $display("including a full pool, out-of-heap bases, wrapped addresses and owner misses.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d results did not match", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
